FILE: design/ssh_pkg.sv
`default_nettype none

package ssh_pkg;

   // Default sizes, handed down through the top level parameters
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF  = 32;

   // Fixed field widths
   localparam int WORD_BITS  = 16;
   localparam int CNT_OUT_BITS = 32;
   localparam int TOTAL_BITS = 48;
   localparam int CMD_BITS   = 2;

   // Request command codes
   localparam logic [CMD_BITS-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

   // Control from the sequencer to the statistics unit
   typedef struct packed {
      logic add;
      logic clear;
   } ssh_stats_ctl_type;

   function automatic logic [WORD_BITS-1:0] swap_word(input logic [WORD_BITS-1:0] w,
                                                      input logic swap);
      logic [WORD_BITS-1:0] r;
      r = swap ? {w[7:0], w[15:8]} : w;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/ssh_ram.sv
`default_nettype none

module ssh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/ssh_stats.sv
`default_nettype none

module ssh_stats import ssh_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ssh_stats_ctl_type             ctl,
   input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
   input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
   output logic signed      [SAMPLE_BITS-1:0] left_min,
   output logic signed      [SAMPLE_BITS-1:0] left_max,
   output logic signed      [SAMPLE_BITS-1:0] right_min,
   output logic signed      [SAMPLE_BITS-1:0] right_max,
   output logic                               is_empty,
   output logic             [TOTAL_BITS-1:0]  total
);

   logic signed [SAMPLE_BITS-1:0] left_min_ff, left_max_ff;
   logic signed [SAMPLE_BITS-1:0] right_min_ff, right_max_ff;
   logic                          empty_ff;
   logic [TOTAL_BITS-1:0]         total_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         left_min_ff  <= '0;
         left_max_ff  <= '0;
         right_min_ff <= '0;
         right_max_ff <= '0;
         empty_ff     <= 1'b1;
         total_ff     <= '0;
      end else if (ctl.add) begin
         empty_ff <= 1'b0;
         // first pair after a reset or clear seeds both extremes
         if (empty_ff || left_sample < left_min_ff) begin
            left_min_ff <= left_sample;
         end
         if (empty_ff || left_sample > left_max_ff) begin
            left_max_ff <= left_sample;
         end
         if (empty_ff || right_sample < right_min_ff) begin
            right_min_ff <= right_sample;
         end
         if (empty_ff || right_sample > right_max_ff) begin
            right_max_ff <= right_sample;
         end
         if (total_ff != '1) begin
            total_ff <= total_ff + TOTAL_BITS'(1);
         end
      end
   end

   assign left_min  = left_min_ff;
   assign left_max  = left_max_ff;
   assign right_min = right_min_ff;
   assign right_max = right_max_ff;
   assign is_empty  = empty_ff;
   assign total     = total_ff;

endmodule

`default_nettype wire

FILE: design/stereo_sample_histogram_top.sv
// Two-channel histogram of stereo sample pairs.
// Request channel (req_valid / req_stall): each request carries a command.
//   Add bins the left and right words, optionally byte-swapped (csr_swap_bytes),
//   in their own channel's histogram and updates min, max and the pair total.
//   Read returns both bin counts at req_bin_value plus the statistics on the
//   response channel (rsp_valid / rsp_stall). Clear zeroes all stores.
// An add reads the bin from the synchronous RAM when it is accepted, then
//   writes back the saturated count in ST_ADD. A read registers the RAM output
//   in ST_READ into the response register, which then raises rsp_valid.
// A clear sweeps every one of the 2**SAMPLE_BITS bin addresses (65536 at the
//   default size), one a cycle; req_stall stays high during the sweep.
// Reset starts the same sweep and sets the byte-swap setting to 0. The config
//   register is always ready; write it only while the block is idle.
// A stalled response holds in the output register. Adds and clears are taken
//   meanwhile; a read request is stalled until the pending response is taken.
`default_nettype none

module stereo_sample_histogram_top import ssh_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [CMD_BITS-1:0]         req_command,
   input  wire logic [WORD_BITS-1:0]        req_left_word,
   input  wire logic [WORD_BITS-1:0]        req_right_word,
   input  wire logic signed [WORD_BITS-1:0] req_bin_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [CNT_OUT_BITS-1:0]          rsp_left_count,
   output logic [CNT_OUT_BITS-1:0]          rsp_right_count,
   output logic signed [WORD_BITS-1:0]     rsp_left_min,
   output logic signed [WORD_BITS-1:0]     rsp_left_max,
   output logic signed [WORD_BITS-1:0]     rsp_right_min,
   output logic signed [WORD_BITS-1:0]     rsp_right_max,
   output logic                             rsp_is_empty,
   output logic [TOTAL_BITS-1:0]            rsp_sample_total,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_swap_bytes
);

   localparam int NBINS = 1 << SAMPLE_BITS;
   localparam int AW    = SAMPLE_BITS;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD,
      ST_READ
   } state_type;

   state_type state_ff, state_in;

   logic                  swap_ff;
   logic [AW-1:0]         clr_addr_ff;
   logic [AW-1:0]         left_addr_ff, right_addr_ff;
   logic                  in_range_ff;

   logic                  rsp_valid_ff;
   logic [CNT_OUT_BITS-1:0] rsp_left_count_ff, rsp_right_count_ff;
   logic signed [WORD_BITS-1:0] rsp_left_min_ff, rsp_left_max_ff;
   logic signed [WORD_BITS-1:0] rsp_right_min_ff, rsp_right_max_ff;
   logic                  rsp_is_empty_ff;
   logic [TOTAL_BITS-1:0] rsp_sample_total_ff;

   logic                  accept;
   logic [WORD_BITS-1:0]  left_w, right_w;
   logic signed [SAMPLE_BITS-1:0] left_s, right_s;
   logic [AW-1:0]         left_idx, right_idx, read_idx;
   logic [WORD_BITS-SAMPLE_BITS:0] read_hi;
   logic                  read_in_range;

   logic                  ram_wr_en, ram_rd_en;
   logic [AW-1:0]         left_wr_addr, right_wr_addr;
   logic [AW-1:0]         left_rd_addr, right_rd_addr;
   logic [COUNT_BITS-1:0] left_q, right_q, left_wr_data, right_wr_data;

   ssh_stats_ctl_type     stats_ctl;
   logic signed [SAMPLE_BITS-1:0] left_min, left_max, right_min, right_max;
   logic                  is_empty;
   logic [TOTAL_BITS-1:0] total;

   // ---- request decode ----
   assign req_stall = (state_ff != ST_IDLE) ||
                      ((req_command == CMD_READ) && rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign left_w  = swap_word(req_left_word, swap_ff);
   assign right_w = swap_word(req_right_word, swap_ff);
   assign left_s  = left_w[SAMPLE_BITS-1:0];
   assign right_s = right_w[SAMPLE_BITS-1:0];

   // offset binary: flip the sign bit to index the bin
   assign left_idx  = {~left_s[SAMPLE_BITS-1], left_s[SAMPLE_BITS-2:0]};
   assign right_idx = {~right_s[SAMPLE_BITS-1], right_s[SAMPLE_BITS-2:0]};
   assign read_idx  = {~req_bin_value[SAMPLE_BITS-1], req_bin_value[SAMPLE_BITS-2:0]};

   // value fits the sample range when all bits from the sample sign upward agree
   assign read_hi       = req_bin_value[WORD_BITS-1:SAMPLE_BITS-1];
   assign read_in_range = (&read_hi) || !(|read_hi);

   // ---- bin memories ----
   assign ram_rd_en     = accept && ((req_command == CMD_ADD) || (req_command == CMD_READ));
   assign left_rd_addr  = (req_command == CMD_READ) ? read_idx : left_idx;
   assign right_rd_addr = (req_command == CMD_READ) ? read_idx : right_idx;

   assign ram_wr_en     = (state_ff == ST_CLEAR) || (state_ff == ST_ADD);
   assign left_wr_addr  = (state_ff == ST_CLEAR) ? clr_addr_ff : left_addr_ff;
   assign right_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : right_addr_ff;

   always_comb begin
      left_wr_data  = '0;
      right_wr_data = '0;
      if (state_ff == ST_ADD) begin
         // saturate at full scale
         left_wr_data  = (left_q == '1) ? left_q : left_q + COUNT_BITS'(1);
         right_wr_data = (right_q == '1) ? right_q : right_q + COUNT_BITS'(1);
      end
   end

   ssh_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NBINS)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (left_wr_addr),
      .wr_data (left_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (left_rd_addr),
      .rd_data (left_q)
   );

   ssh_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NBINS)
   ) u_right_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (right_wr_addr),
      .wr_data (right_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (right_rd_addr),
      .rd_data (right_q)
   );

   // ---- statistics ----
   assign stats_ctl.add   = accept && (req_command == CMD_ADD);
   assign stats_ctl.clear = accept && (req_command == CMD_CLEAR);

   ssh_stats #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_stats (
      .clock        (clock),
      .reset        (reset),
      .ctl          (stats_ctl),
      .left_sample  (left_s),
      .right_sample (right_s),
      .left_min     (left_min),
      .left_max     (left_max),
      .right_min    (right_min),
      .right_max    (right_max),
      .is_empty     (is_empty),
      .total        (total)
   );

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(NBINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_ADD:   state_in = ST_ADD;
                  CMD_READ:  state_in = ST_READ;
                  CMD_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD:  state_in = ST_IDLE;
         ST_READ: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         swap_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            swap_ff <= csr_swap_bytes;
         end
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end else begin
            clr_addr_ff <= '0;
         end
         // hold a stalled response, drop it once taken
         rsp_valid_ff <= (state_ff == ST_READ) || (rsp_valid_ff && rsp_stall);
      end

      if (accept) begin
         left_addr_ff  <= left_idx;
         right_addr_ff <= right_idx;
         in_range_ff   <= read_in_range;
      end

      if (state_ff == ST_READ) begin
         rsp_left_count_ff   <= in_range_ff ? CNT_OUT_BITS'(left_q) : '0;
         rsp_right_count_ff  <= in_range_ff ? CNT_OUT_BITS'(right_q) : '0;
         rsp_left_min_ff     <= WORD_BITS'(left_min);
         rsp_left_max_ff     <= WORD_BITS'(left_max);
         rsp_right_min_ff    <= WORD_BITS'(right_min);
         rsp_right_max_ff    <= WORD_BITS'(right_max);
         rsp_is_empty_ff     <= is_empty;
         rsp_sample_total_ff <= total;
      end
   end

   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_count   = rsp_left_count_ff;
   assign rsp_right_count  = rsp_right_count_ff;
   assign rsp_left_min     = rsp_left_min_ff;
   assign rsp_left_max     = rsp_left_max_ff;
   assign rsp_right_min    = rsp_right_min_ff;
   assign rsp_right_max    = rsp_right_max_ff;
   assign rsp_is_empty     = rsp_is_empty_ff;
   assign rsp_sample_total = rsp_sample_total_ff;

endmodule

`default_nettype wire

FILE: tb/stereo_sample_histogram_top_tb.sv
`timescale 1ns / 100ps

module stereo_sample_histogram_top_tb;
   import ssh_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT = 200000;

   typedef struct {
      logic [CMD_BITS-1:0]         cmd;
      logic [WORD_BITS-1:0]        left_word;
      logic [WORD_BITS-1:0]        right_word;
      logic signed [WORD_BITS-1:0] bin_value;
      bit                          drain;
   } hist_request_type;

   typedef struct {
      logic [CNT_OUT_BITS-1:0]     left_count;
      logic [CNT_OUT_BITS-1:0]     right_count;
      logic signed [WORD_BITS-1:0] left_min;
      logic signed [WORD_BITS-1:0] left_max;
      logic signed [WORD_BITS-1:0] right_min;
      logic signed [WORD_BITS-1:0] right_max;
      logic                        is_empty;
      logic [TOTAL_BITS-1:0]       sample_total;
   } bin_reading_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [CMD_BITS-1:0]         req_command;
   logic [WORD_BITS-1:0]        req_left_word;
   logic [WORD_BITS-1:0]        req_right_word;
   logic signed [WORD_BITS-1:0] req_bin_value;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [CNT_OUT_BITS-1:0]     rsp_left_count;
   logic [CNT_OUT_BITS-1:0]     rsp_right_count;
   logic signed [WORD_BITS-1:0] rsp_left_min;
   logic signed [WORD_BITS-1:0] rsp_left_max;
   logic signed [WORD_BITS-1:0] rsp_right_min;
   logic signed [WORD_BITS-1:0] rsp_right_max;
   logic                        rsp_is_empty;
   logic [TOTAL_BITS-1:0]       rsp_sample_total;
   logic                        csr_valid;
   logic                        csr_ready;
   logic                        csr_swap_bytes;

   // predicted block state
   bit [CNT_OUT_BITS-1:0]       left_hist [bit [WORD_BITS-1:0]];
   bit [CNT_OUT_BITS-1:0]       right_hist [bit [WORD_BITS-1:0]];
   logic signed [WORD_BITS-1:0] left_lo, left_hi, right_lo, right_hi;
   bit                          hist_empty;
   logic [TOTAL_BITS-1:0]       pair_cnt;
   bit                          swap_cfg;

   hist_request_type request_q [$];
   bin_reading_type  read_result_q [$];
   logic [WORD_BITS-1:0] word_pool [16];

   bit req_taken;
   bit hold_go;
   bit rsp_hold_on;
   int send_idle_pct;
   int recv_idle_pct;
   int pushed_cnt;
   int accepted_cnt;
   int errors;
   int reads_checked;
   int adds_taken;
   int clears_taken;
   int csr_writes;

   stereo_sample_histogram_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_left_word    (req_left_word),
      .req_right_word   (req_right_word),
      .req_bin_value    (req_bin_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_count   (rsp_left_count),
      .rsp_right_count  (rsp_right_count),
      .rsp_left_min     (rsp_left_min),
      .rsp_left_max     (rsp_left_max),
      .rsp_right_min    (rsp_right_min),
      .rsp_right_max    (rsp_right_max),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_sample_total (rsp_sample_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_swap_bytes   (csr_swap_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic void clear_hist();
      left_hist.delete();
      right_hist.delete();
      left_lo    = '0;
      left_hi    = '0;
      right_lo   = '0;
      right_hi   = '0;
      hist_empty = 1'b1;
      pair_cnt   = '0;
   endfunction

   function automatic logic signed [WORD_BITS-1:0] word_to_sample(input logic [WORD_BITS-1:0] w);
      return swap_cfg ? {w[7:0], w[15:8]} : w;
   endfunction

   task automatic check_field(input string what, input logic [TOTAL_BITS-1:0] want,
                              input logic [TOTAL_BITS-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   // model the block on every handshake, check responses against pending reads
   always @(posedge clock) begin : hist_monitor
      logic signed [WORD_BITS-1:0] ls, rs;
      bin_reading_type want;
      req_taken = 1'b0;
      if (reset) begin
         swap_cfg = 1'b0;
         clear_hist();
      end else begin
         if (csr_valid && csr_ready) begin
            swap_cfg = csr_swap_bytes;
            csr_writes++;
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (read_result_q.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected response, expected none, actual counts %0h %0h",
                        $time, rsp_left_count, rsp_right_count);
            end else begin
               want = read_result_q.pop_front();
               reads_checked++;
               check_field("left_count", want.left_count, rsp_left_count);
               check_field("right_count", want.right_count, rsp_right_count);
               check_field("left_min", want.left_min, rsp_left_min);
               check_field("left_max", want.left_max, rsp_left_max);
               check_field("right_min", want.right_min, rsp_right_min);
               check_field("right_max", want.right_max, rsp_right_max);
               check_field("is_empty", want.is_empty, rsp_is_empty);
               check_field("sample_total", want.sample_total, rsp_sample_total);
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            accepted_cnt++;
            case (req_command)
               CMD_ADD: begin
                  adds_taken++;
                  ls = word_to_sample(req_left_word);
                  rs = word_to_sample(req_right_word);
                  if (!left_hist.exists(ls)) left_hist[ls] = '0;
                  if (!right_hist.exists(rs)) right_hist[rs] = '0;
                  if (left_hist[ls] != '1) left_hist[ls]++;
                  if (right_hist[rs] != '1) right_hist[rs]++;
                  if (hist_empty) begin
                     left_lo    = ls;
                     left_hi    = ls;
                     right_lo   = rs;
                     right_hi   = rs;
                     hist_empty = 1'b0;
                  end else begin
                     if (ls < left_lo) left_lo = ls;
                     if (ls > left_hi) left_hi = ls;
                     if (rs < right_lo) right_lo = rs;
                     if (rs > right_hi) right_hi = rs;
                  end
                  if (pair_cnt != '1) pair_cnt++;
               end
               CMD_READ: begin
                  want.left_count   = left_hist.exists(req_bin_value) ?
                                      left_hist[req_bin_value] : '0;
                  want.right_count  = right_hist.exists(req_bin_value) ?
                                      right_hist[req_bin_value] : '0;
                  want.left_min     = left_lo;
                  want.left_max     = left_hi;
                  want.right_min    = right_lo;
                  want.right_max    = right_hi;
                  want.is_empty     = hist_empty;
                  want.sample_total = pair_cnt;
                  read_result_q.push_back(want);
               end
               CMD_CLEAR: begin
                  clears_taken++;
                  clear_hist();
               end
               default: ;
            endcase
         end
      end
   end

   // request driver: advance only after a handshake or while idle
   always @(negedge clock) begin : req_driver
      hist_request_type nxt;
      if (!reset && (!req_valid || req_taken)) begin
         while (request_q.size() != 0 && request_q[0].drain && read_result_q.size() == 0)
            void'(request_q.pop_front());
         if (request_q.size() != 0 && !request_q[0].drain &&
             $urandom_range(99) >= send_idle_pct) begin
            nxt = request_q.pop_front();
            req_valid      <= 1'b1;
            req_command    <= nxt.cmd;
            req_left_word  <= nxt.left_word;
            req_right_word <= nxt.right_word;
            req_bin_value  <= nxt.bin_value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && (rsp_hold_on || $urandom_range(99) < recv_idle_pct);
   end

   // long receiver hold-off so that pending reads back up into the request port
   initial begin
      rsp_hold_on = 1'b0;
      wait (hold_go);
      @(negedge clock);
      rsp_hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rsp_hold_on <= 1'b0;
   end

   task automatic queue_request(input logic [CMD_BITS-1:0] cmd, input logic [WORD_BITS-1:0] lw,
                                input logic [WORD_BITS-1:0] rw,
                                input logic signed [WORD_BITS-1:0] bv);
      hist_request_type rq;
      rq.cmd        = cmd;
      rq.left_word  = lw;
      rq.right_word = rw;
      rq.bin_value  = bv;
      rq.drain      = 1'b0;
      request_q.push_back(rq);
      pushed_cnt++;
   endtask

   task automatic queue_drain();
      hist_request_type rq;
      rq = '{cmd: CMD_ADD, left_word: '0, right_word: '0, bin_value: '0, drain: 1'b1};
      request_q.push_back(rq);
   endtask

   function automatic logic [WORD_BITS-1:0] pick_word();
      logic [WORD_BITS-1:0] w;
      if ($urandom_range(1) == 1) return word_pool[$urandom_range(15)];
      w = WORD_BITS'($urandom);
      word_pool[$urandom_range(15)] = w;
      return w;
   endfunction

   function automatic logic [WORD_BITS-1:0] rnd_word();
      return WORD_BITS'($urandom);
   endfunction

   // mostly adds and reads aimed at values already binned, with some noise
   task automatic fill_random(input int n, input bit swap_now, input int clear_at);
      int r;
      logic [WORD_BITS-1:0] w;
      logic signed [WORD_BITS-1:0] bv;
      for (int i = 0; i < n; i++) begin
         if (i == clear_at) queue_request(CMD_CLEAR, rnd_word(), rnd_word(), rnd_word());
         if (i % 97 == 96) queue_drain();
         r = $urandom_range(99);
         if (r < 55) begin
            queue_request(CMD_ADD, pick_word(), pick_word(), rnd_word());
         end else if (r < 95) begin
            w = word_pool[$urandom_range(15)];
            if ($urandom_range(9) < 6) bv = swap_now ? {w[7:0], w[15:8]} : w;
            else bv = rnd_word();
            queue_request(CMD_READ, rnd_word(), rnd_word(), bv);
         end else begin
            queue_request(CMD_UNUSED, rnd_word(), rnd_word(), rnd_word());
         end
      end
   endtask

   // hold until every request is taken, every read answered and any clear sweep done
   task automatic settle();
      while (accepted_cnt != pushed_cnt) @(negedge clock);
      while (read_result_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      while (req_stall) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_swap(input bit v);
      csr_valid      <= 1'b1;
      csr_swap_bytes <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int waited;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = CMD_ADD;
      req_left_word  = '0;
      req_right_word = '0;
      req_bin_value  = '0;
      csr_valid      = 1'b0;
      csr_swap_bytes = 1'b0;
      send_idle_pct  = 28;
      recv_idle_pct  = 62;
      for (int i = 0; i < 16; i++) word_pool[i] = WORD_BITS'($urandom);
      word_pool[0] = 16'h8000;
      word_pool[1] = 16'h7FFF;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      settle();

      // directed, plain byte order
      write_swap(1'b0);
      @(posedge clock);
      queue_request(CMD_READ, 16'h0000, 16'h0000, 16'sd0);
      queue_request(CMD_ADD, 16'h0000, 16'hFFFF, 16'sd0);
      queue_request(CMD_ADD, 16'h7FFF, 16'h8000, 16'sd0);
      queue_request(CMD_ADD, 16'h8000, 16'h7FFF, 16'sd0);
      queue_request(CMD_ADD, 16'h0001, 16'h0100, 16'sd0);
      queue_request(CMD_ADD, 16'h7FFF, 16'h7FFF, 16'sd0);
      queue_request(CMD_READ, 16'hFFFF, 16'hFFFF, -16'sd32768);
      queue_request(CMD_READ, 16'h0000, 16'h0000, 16'sd32767);
      queue_request(CMD_READ, 16'hFFFF, 16'h0000, -16'sd1);
      queue_request(CMD_READ, 16'h0000, 16'hFFFF, 16'sd0);
      queue_request(CMD_READ, 16'h5555, 16'hAAAA, 16'sd1);
      queue_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF, -16'sd1);
      queue_request(CMD_READ, 16'hAAAA, 16'h5555, 16'sd256);
      queue_request(CMD_CLEAR, 16'hFFFF, 16'hFFFF, -16'sd1);
      queue_request(CMD_READ, 16'h0000, 16'h0000, 16'sd32767);
      queue_request(CMD_ADD, 16'h1234, 16'hFEDC, 16'sd0);
      queue_request(CMD_READ, 16'h0000, 16'h0000, 16'sh1234);
      settle();

      // directed, swapped byte order
      write_swap(1'b1);
      @(posedge clock);
      queue_request(CMD_ADD, 16'h0080, 16'h8000, 16'sd0);
      queue_request(CMD_ADD, 16'hFF7F, 16'h3412, 16'sd0);
      queue_request(CMD_READ, 16'h0000, 16'h0000, -16'sd32768);
      queue_request(CMD_READ, 16'h0000, 16'h0000, 16'sd128);
      queue_request(CMD_READ, 16'h0000, 16'h0000, 16'sh1234);
      queue_request(CMD_UNUSED, 16'h0000, 16'h0000, 16'sd0);
      settle();

      // random, sender idles less than receiver
      @(posedge clock);
      fill_random(420, 1'b1, 210);
      settle();

      write_swap(1'b0);
      @(posedge clock);
      send_idle_pct <= 62;
      recv_idle_pct <= 28;
      fill_random(420, 1'b0, 0);
      settle();

      // no idling; hold the receiver off while reads pile up
      write_swap(1'b1);
      @(posedge clock);
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      hold_go = 1'b1;
      for (int i = 0; i < 20; i++) begin
         queue_request(CMD_READ, rnd_word(), rnd_word(), rnd_word());
         queue_request(CMD_ADD, pick_word(), pick_word(), rnd_word());
      end
      fill_random(380, 1'b1, 150);

      while (accepted_cnt != pushed_cnt) @(negedge clock);
      waited = 0;
      while (read_result_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (read_result_q.size() != 0) begin
         errors += read_result_q.size();
         $display("%0t ns: %0d reads never answered, expected responses, actual none",
                  $time, read_result_q.size());
      end
      repeat (20) @(negedge clock);

      $display("Run covered %0d requests: %0d adds, %0d clears, %0d reads checked,",
               accepted_cnt, adds_taken, clears_taken, reads_checked);
      $display("  %0d byte-swap settings, a long response hold-off and drained pauses",
               csr_writes);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
